// ===== hdl/rfpl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rfpl_pkg;

    localparam int FRAME_LEN = 15;
    localparam int CRC_LEN   = 13;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 4;

    localparam logic [7:0]  WAIT_LIMIT_RST = 8'd10;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [23:0] COORD_OFFSET   = 24'h800000;
    localparam logic [7:0]  STATUS_ZERO    = 8'h00;

    typedef enum logic [2:0] {
        ST_WAIT      = 3'd0,
        ST_CRC_ERR   = 3'd1,
        ST_PEAK      = 3'd2,
        ST_EMIT      = 3'd3,
        ST_PAST_PEAK = 3'd4
    } status_t;

    // fields of a finished frame as seen at the end marker
    typedef struct packed {
        logic        len_ok;
        logic        status_nz;
        logic        crc_ok;
        logic [7:0]  level;
        logic [15:0] tag;
        logic [23:0] x;
        logic [23:0] y;
    } frame_info_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] tag;
        logic [23:0] x;
        logic [23:0] y;
        logic [7:0]  level;
        logic [7:0]  peak;
    } result_t;

    // modbus crc16, one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rfpl_frame_rx.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfpl_frame_rx (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                byte_we,
    input  wire logic [7:0]          byte_in,
    input  wire logic                frame_end,
    output rfpl_pkg::frame_info_t    info
);
    import rfpl_pkg::*;

    localparam logic [CNT_W-1:0] LEN_C  = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] OVER_C = CNT_W'(FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] CRC_C  = CNT_W'(CRC_LEN);

    logic [7:0]       frame_reg [FRAME_LEN];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;

    always_comb begin
        count_next = count_reg;
        crc_next   = crc_reg;
        if (frame_end) begin
            count_next = '0;
            crc_next   = CRC_INIT;
        end else if (byte_we) begin
            if (count_reg < LEN_C) begin
                count_next = count_reg + 1'b1;
                if (count_reg < CRC_C) begin
                    crc_next = crc16_byte(crc_reg, byte_in);
                end
            end else begin
                count_next = OVER_C;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
        end else begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // byte store, no reset: a frame of full length writes every entry before it is checked
    always_ff @(posedge aclk) begin
        if (byte_we && !frame_end && count_reg < LEN_C) begin
            frame_reg[count_reg[IDX_W-1:0]] <= byte_in;
        end
    end

    always_comb begin
        info.len_ok    = (count_reg == LEN_C);
        info.status_nz = (frame_reg[3] != STATUS_ZERO);
        info.crc_ok    = ({frame_reg[14], frame_reg[13]} == crc_reg);
        info.level     = frame_reg[4];
        info.tag       = {frame_reg[5], frame_reg[6]};
        info.x         = {frame_reg[7], frame_reg[8], frame_reg[9]} ^ COORD_OFFSET;
        info.y         = {frame_reg[10], frame_reg[11], frame_reg[12]} ^ COORD_OFFSET;
    end

endmodule

`default_nettype wire

// ===== hdl/rfpl_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfpl_tracker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                frame_end,
    input  wire rfpl_pkg::frame_info_t info,
    input  wire logic [7:0]          wait_limit,
    output rfpl_pkg::result_t        res
);
    import rfpl_pkg::*;

    logic [7:0]  idle_reg, idle_next;
    logic [7:0]  peak_reg, peak_next;
    logic        armed_reg, armed_next;
    logic [23:0] x_reg, x_next;
    logic [23:0] y_reg, y_next;
    logic [15:0] tag_reg, tag_next;
    logic [7:0]  level_reg, level_next;
    status_t     status;
    logic [7:0]  idle_inc;

    always_comb begin
        idle_next  = idle_reg;
        peak_next  = peak_reg;
        armed_next = armed_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        tag_next   = tag_reg;
        level_next = level_reg;
        status     = ST_WAIT;
        idle_inc   = idle_reg + 8'd1;
        if (!info.len_ok || !info.status_nz) begin
            idle_next = idle_inc;
            if (idle_inc >= wait_limit) begin
                idle_next  = '0;
                peak_next  = '0;
                armed_next = 1'b1;
                tag_next   = '0;
            end
        end else begin
            idle_next  = '0;
            tag_next   = info.tag;
            level_next = info.level;
            if (!info.crc_ok) begin
                status = ST_CRC_ERR;
            end else if (info.level >= peak_reg) begin
                status    = ST_PEAK;
                peak_next = info.level;
                x_next    = info.x;
                y_next    = info.y;
            end else if (armed_reg) begin
                status     = ST_EMIT;
                armed_next = 1'b0;
            end else begin
                status = ST_PAST_PEAK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg  <= '0;
            peak_reg  <= '0;
            armed_reg <= 1'b1;
            x_reg     <= '0;
            y_reg     <= '0;
            tag_reg   <= '0;
            level_reg <= '0;
        end else if (frame_end) begin
            idle_reg  <= idle_next;
            peak_reg  <= peak_next;
            armed_reg <= armed_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            tag_reg   <= tag_next;
            level_reg <= level_next;
        end
    end

    always_comb begin
        res.status = status;
        res.tag    = tag_next;
        res.x      = x_next;
        res.y      = y_next;
        res.level  = level_next;
        res.peak   = peak_next;
    end

endmodule

`default_nettype wire

// ===== hdl/rfid_frame_peak_locator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// RFID frame peak locator. Reader response bytes arrive one per beat with
// s_cmd low; a beat with s_cmd high closes the read and yields exactly one
// result beat. A read is checked for a length of 15 bytes, a nonzero status
// byte and a Modbus CRC-16 over bytes 0..12 (low byte in 13, high in 14).
// Good frames raise the held peak and capture X/Y (offset binary converted
// to two's complement), or report the held position once when the signal
// falls below the peak. wait_limit empty or idle reads in a row clear peak
// and tag and re-arm the report. Throughput is one beat per cycle: each beat
// sits in the input register, where the byte-wide crc step and the tracker
// compare handle it; only an end marker meeting a full result register that
// is not being taken holds the input side. A result beat is registered and
// offered on m_valid as its end marker leaves the input register. cfg_data
// sets wait_limit and is only to be written while no read is in flight.
module rfid_frame_peak_locator_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input beats
    input  wire logic               s_valid,
    output      logic               s_ready,
    input  wire logic               s_cmd,
    input  wire logic [7:0]         s_data_byte,
    // result beats
    output      logic               m_valid,
    input  wire logic               m_ready,
    output      logic [2:0]         m_status,
    output      logic [15:0]        m_tag_number,
    output      logic signed [23:0] m_pos_x,
    output      logic signed [23:0] m_pos_y,
    output      logic [7:0]         m_signal_now,
    output      logic [7:0]         m_signal_peak,
    // wait_limit write
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [7:0]         cfg_data
);
    import rfpl_pkg::*;

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic [7:0]  wait_limit_reg;
    logic        proc_fire;
    logic        byte_we;
    logic        frame_end;
    frame_info_t info;
    result_t     res;

    // a byte beat never waits; an end marker needs room in the result register
    assign proc_fire = in_valid_reg && (!in_cmd_reg || !out_valid_reg || m_ready);
    assign byte_we   = proc_fire && !in_cmd_reg;
    assign frame_end = proc_fire && in_cmd_reg;
    assign s_ready   = !in_valid_reg || proc_fire;
    assign cfg_ready = 1'b1;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg  <= s_cmd;
            in_byte_reg <= s_data_byte;
        end
    end

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_limit_reg <= WAIT_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            wait_limit_reg <= cfg_data;
        end
    end

    // byte store and running crc
    rfpl_frame_rx u_frame_rx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_we   (byte_we),
        .byte_in   (in_byte_reg),
        .frame_end (frame_end),
        .info      (info)
    );

    // idle count, peak hold and position tracking
    rfpl_tracker u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_end  (frame_end),
        .info       (info),
        .wait_limit (wait_limit_reg),
        .res        (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (frame_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_end) begin
            out_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_reg.status;
    assign m_tag_number  = out_reg.tag;
    assign m_pos_x       = $signed(out_reg.x);
    assign m_pos_y       = $signed(out_reg.y);
    assign m_signal_now  = out_reg.level;
    assign m_signal_peak = out_reg.peak;

endmodule

`default_nettype wire
